FILE: rtl/core/max_tracking_fifo_core_macros.svh
// ----------------------------------------------------------------------------
// Max tracking FIFO core: assertion macros
// Shared property forms for the checker; clk and rst_n come from the scope.
// ----------------------------------------------------------------------------
`ifndef MAX_TRACKING_FIFO_CORE_MACROS_SVH
`define MAX_TRACKING_FIFO_CORE_MACROS_SVH

// Same-cycle implication.
`define MTF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtf: same-cycle check failed");

// Next-cycle implication.
`define MTF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtf: next-cycle check failed");

`endif

FILE: rtl/core/mtf_pkg.sv
// ----------------------------------------------------------------------------
// Max tracking FIFO package
// Opcodes, status codes, sequencer states and the stack entry layout.
// ----------------------------------------------------------------------------
package mtf_pkg;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_MAXIMUM = 2'd2,
        OP_EMPTY   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_XFER,
        S_POP_RD,
        S_POP_WB
    } state_t;

    // One stack slot: the value and the maximum of all slots below it.
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] below_max;
    } stack_entry_t;

    localparam logic signed [31:0] EMPTY_SENTINEL = -32'sd2147483647;

endpackage

FILE: rtl/core/max_tracking_fifo_core.sv
// ----------------------------------------------------------------------------
// Max tracking FIFO core
// FIFO of signed 32-bit values that also reports the largest value held.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the opcode (enqueue,
//   dequeue, maximum, empty query), s_tdata the value to enqueue. Every
//   request yields one response on the m_ channel: m_tdata is the dequeued
//   value or maximum, m_tuser carries the empty flag and a status code.
//   Enqueue, maximum, empty query and a dequeue of an empty queue answer
//   in the cycle after the request is taken and sustain one request per
//   cycle while the receiver keeps up. Any other dequeue reads the output
//   stack RAM and answers from S_POP_WB, taking no request meanwhile. When
//   the output stack is empty the dequeue first streams the input stack
//   across in S_XFER, one entry per cycle through the RAM read port.
//   Reset clears both counts; RAM contents are never cleared, since only
//   slots below a count are ever read. No clearing pass.
//   A stalled receiver holds the response register; the next request is
//   still taken in the cycle the pending response drains.
// ----------------------------------------------------------------------------
module max_tracking_fifo_core #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_in
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [2:0]  m_tuser    // [0] is_empty, [2:1] status
);
    import mtf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] TOTAL_FULL = (CW + 1)'(DEPTH);

    // Sequencer and counts
    state_t             state_reg, state_next;
    logic [CW-1:0]      in_count_reg, in_count_next;
    logic [CW-1:0]      out_count_reg, out_count_next;
    // Cached top-of-stack running maxima (include the top entry itself)
    logic signed [31:0] in_top_reg, in_top_next;
    logic signed [31:0] out_top_reg, out_top_next;

    // Response register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg;
    logic               out_empty_reg;
    status_t            out_status_reg;

    logic               accept;
    opcode_t            op;
    logic signed [31:0] value_in;
    logic [CW:0]        total;
    logic [CW-1:0]      in_dec, out_dec;
    logic signed [31:0] in_push_max;
    logic signed [31:0] xfer_v, xfer_max;
    logic signed [31:0] max_value;
    status_t            max_status;

    logic               res_load;
    logic signed [31:0] res_value;
    logic               res_empty;
    status_t            res_status;

    // RAM ports
    logic               in_wr_en, in_rd_en, out_wr_en, out_rd_en;
    logic [AW-1:0]      in_wr_addr, in_rd_addr, out_wr_addr, out_rd_addr;
    stack_entry_t       in_wr_data, in_rd_data, out_wr_data, out_rd_data;

    mtf_stack #(.DEPTH(DEPTH)) u_in_stack (
        .clk     (clk),
        .wr_en   (in_wr_en),
        .wr_addr (in_wr_addr),
        .wr_data (in_wr_data),
        .rd_en   (in_rd_en),
        .rd_addr (in_rd_addr),
        .rd_data (in_rd_data)
    );

    mtf_stack #(.DEPTH(DEPTH)) u_out_stack (
        .clk     (clk),
        .wr_en   (out_wr_en),
        .wr_addr (out_wr_addr),
        .wr_data (out_wr_data),
        .rd_en   (out_rd_en),
        .rd_addr (out_rd_addr),
        .rd_data (out_rd_data)
    );

    // Handshake: only idle takes requests, and only if the response slot
    // is free or draining this cycle.
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser);
    assign value_in = s_tdata;

    assign total   = {1'b0, in_count_reg} + {1'b0, out_count_reg};
    assign in_dec  = in_count_reg - CW'(1);
    assign out_dec = out_count_reg - CW'(1);

    // Running max for a push onto the input stack
    assign in_push_max = (in_count_reg != '0 && in_top_reg > value_in) ? in_top_reg
                                                                       : value_in;

    // Entry moving across during a transfer
    assign xfer_v   = in_rd_data.value;
    assign xfer_max = (out_count_reg != '0 && out_top_reg > xfer_v) ? out_top_reg : xfer_v;

    // Maximum query, only over stacks that hold something
    always_comb
    begin
        max_value  = EMPTY_SENTINEL;
        max_status = ST_OK;
        if (total == '0)
        begin
            max_status = ST_EMPTY;
        end
        else if (out_count_reg == '0)
        begin
            max_value = in_top_reg;
        end
        else if (in_count_reg == '0)
        begin
            max_value = out_top_reg;
        end
        else
        begin
            max_value = (in_top_reg > out_top_reg) ? in_top_reg : out_top_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_DEQUEUE && total != '0)
                begin
                    state_next = (out_count_reg == '0) ? S_XFER : S_POP_WB;
                end
            end
            S_XFER:
            begin
                if (in_count_reg == '0)
                begin
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                state_next = S_POP_WB;
            end
            S_POP_WB:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control. A RAM write and a read of the same slot are
    // never issued in the same cycle: the pop read after a transfer comes in
    // the cycle after the last write, so no forwarding is needed.
    always_comb
    begin
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        in_top_next    = in_top_reg;
        out_top_next   = out_top_reg;

        in_wr_en    = 1'b0;
        in_wr_addr  = in_count_reg[AW-1:0];
        in_wr_data  = '{value: value_in, below_max: in_top_reg};
        in_rd_en    = 1'b0;
        in_rd_addr  = in_dec[AW-1:0];
        out_wr_en   = 1'b0;
        out_wr_addr = out_count_reg[AW-1:0];
        out_wr_data = '{value: xfer_v, below_max: out_top_reg};
        out_rd_en   = 1'b0;
        out_rd_addr = out_dec[AW-1:0];

        res_load   = 1'b0;
        res_value  = '0;
        res_empty  = (total == '0);
        res_status = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_ENQUEUE:
                        begin
                            res_load = 1'b1;
                            if (total == TOTAL_FULL)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                in_wr_en      = 1'b1;
                                in_top_next   = in_push_max;
                                in_count_next = in_count_reg + CW'(1);
                                res_empty     = 1'b0;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (total == '0)
                            begin
                                res_load   = 1'b1;
                                res_value  = EMPTY_SENTINEL;
                                res_status = ST_EMPTY;
                            end
                            else if (out_count_reg == '0)
                            begin
                                // start transfer: fetch input stack top
                                in_rd_en      = 1'b1;
                                in_count_next = in_dec;
                            end
                            else
                            begin
                                out_rd_en = 1'b1;
                            end
                        end
                        OP_MAXIMUM:
                        begin
                            res_load   = 1'b1;
                            res_value  = max_value;
                            res_status = max_status;
                        end
                        OP_EMPTY:
                        begin
                            res_load = 1'b1;
                        end
                        default:
                        begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_XFER:
            begin
                // push fetched entry, fetch the next one under it
                out_wr_en      = 1'b1;
                out_top_next   = xfer_max;
                out_count_next = out_count_reg + CW'(1);
                if (in_count_reg != '0)
                begin
                    in_rd_en      = 1'b1;
                    in_count_next = in_dec;
                end
            end
            S_POP_RD:
            begin
                out_rd_en = 1'b1;
            end
            S_POP_WB:
            begin
                out_count_next = out_dec;
                if (out_count_reg > CW'(1))
                begin
                    out_top_next = out_rd_data.below_max;
                end
                res_load   = 1'b1;
                res_value  = out_rd_data.value;
                res_empty  = (total == (CW + 1)'(1));
                res_status = ST_OK;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Response slot: loads only when free or draining (guaranteed by s_tready)
    always_comb
    begin
        priority if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_top_reg  <= in_top_next;
        out_top_reg <= out_top_next;
        if (res_load)
        begin
            out_value_reg  <= res_value;
            out_empty_reg  <= res_empty;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = {out_status_reg, out_empty_reg};

endmodule

FILE: rtl/core/mtf_stack.sv
// ----------------------------------------------------------------------------
// Stack storage
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module mtf_stack #(
    parameter int DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  mtf_pkg::stack_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output mtf_pkg::stack_entry_t rd_data
);
    import mtf_pkg::*;

    stack_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/mtf_checker.sv
// ----------------------------------------------------------------------------
// Max tracking FIFO checker
// Port-level checks on the response channel, bound to the core.
// ----------------------------------------------------------------------------
`include "max_tracking_fifo_core_macros.svh"

module mtf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import mtf_pkg::*;

    // dropped enqueue: zero payload, queue cannot be empty
    `MTF_ASSERT_IMP(a_full_resp, m_tvalid && m_tuser[2:1] == ST_FULL, m_tdata == 32'd0 && !m_tuser[0])

    // empty dequeue or maximum: sentinel and empty flag together
    `MTF_ASSERT_IMP(a_empty_resp, m_tvalid && m_tuser[2:1] == ST_EMPTY, m_tdata == EMPTY_SENTINEL && m_tuser[0])

    // stalled response holds
    `MTF_ASSERT_NXT(a_resp_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind max_tracking_fifo_core mtf_checker u_mtf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/max_tracking_fifo_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max tracking FIFO core testbench
// Directed table, then random enqueue/dequeue/max/empty traffic in bursts,
// with random source gaps and sink back-pressure; every response is scored
// against its typed-in row or a two-stack model of the queue in the bench.
// ----------------------------------------------------------------------------
module max_tracking_fifo_core_tb;

    import mtf_pkg::*;

    localparam int DEPTH          = 64;
    localparam int CLK_PERIOD     = 20;
    localparam int HOLD_CYCLES    = 300;   // long sink hold-off, fills the core
    localparam int PHASE_REQUESTS = 150;
    localparam int NUM_PHASES     = 4;
    localparam int NUM_DIRECTED   = 25;

    // One response as seen on the m_ channel.
    typedef struct packed {
        logic signed [31:0] value;
        logic               is_empty;
        status_t            status;
    } response_t;

    // Directed row: request plus, where obvious, the response typed in.
    typedef struct packed {
        opcode_t            op;
        logic [31:0]        value;
        bit                 typed;
        logic signed [31:0] exp_value;
        bit                 exp_empty;
        status_t            exp_status;
    } directed_row_t;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED
    } burst_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value_in
    logic [1:0]  s_tuser;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] result_value
    logic [2:0]  m_tuser;   // [0] is_empty, [2:1] status

    max_tracking_fifo_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // Queue model: input stack and output stack, each slot holding the
    // value and the running max of itself and everything below it.
    // ------------------------------------------------------------------
    logic signed [31:0] in_val  [DEPTH];
    logic signed [31:0] in_max  [DEPTH];
    logic signed [31:0] out_val [DEPTH];
    logic signed [31:0] out_max [DEPTH];
    int                 in_cnt;
    int                 out_cnt;

    response_t          expected_responses [$];

    // Knobs shared between the source, sink and sequence.
    int send_idle_pct;
    int stall_pct;
    int hold_trigger;
    int hold_seen;
    int hold_left;

    // Bookkeeping for the summary.
    int requests_sent;
    int responses_seen;
    int mismatches;
    int full_drops;
    int empty_hits;
    int stack_moves;
    int peak_fill;

    directed_row_t directed_rows [NUM_DIRECTED];

    // Advances the model by one request and returns the response it owes.
    function automatic response_t predict_response(opcode_t op, logic signed [31:0] v);
        response_t          r;
        logic signed [31:0] a;
        logic signed [31:0] b;
        r.value  = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQUEUE:
            begin
                if (in_cnt + out_cnt >= DEPTH)
                begin
                    r.status = ST_FULL;
                    full_drops++;
                end
                else
                begin
                    in_val[in_cnt] = v;
                    in_max[in_cnt] = (in_cnt > 0 && in_max[in_cnt-1] > v) ? in_max[in_cnt-1] : v;
                    in_cnt++;
                end
            end
            OP_DEQUEUE:
            begin
                // Output stack dry: pour the input stack across, order reverses.
                if (out_cnt == 0 && in_cnt > 0)
                begin
                    stack_moves++;
                    while (in_cnt > 0)
                    begin
                        in_cnt--;
                        out_val[out_cnt] = in_val[in_cnt];
                        out_max[out_cnt] = (out_cnt > 0 && out_max[out_cnt-1] > in_val[in_cnt])
                                           ? out_max[out_cnt-1] : in_val[in_cnt];
                        out_cnt++;
                    end
                end
                if (out_cnt > 0)
                begin
                    out_cnt--;
                    r.value = out_val[out_cnt];
                end
                else
                begin
                    r.value  = EMPTY_SENTINEL;
                    r.status = ST_EMPTY;
                    empty_hits++;
                end
            end
            OP_MAXIMUM:
            begin
                // Only non-empty stacks take part, so the most negative value
                // is never masked by the sentinel.
                if (in_cnt == 0 && out_cnt == 0)
                begin
                    r.value  = EMPTY_SENTINEL;
                    r.status = ST_EMPTY;
                    empty_hits++;
                end
                else if (in_cnt == 0)
                    r.value = out_max[out_cnt-1];
                else if (out_cnt == 0)
                    r.value = in_max[in_cnt-1];
                else
                begin
                    a = in_max[in_cnt-1];
                    b = out_max[out_cnt-1];
                    r.value = (a > b) ? a : b;
                end
            end
            default: ;   // empty query: zero value, status ok
        endcase
        r.is_empty = (in_cnt + out_cnt == 0);
        if (in_cnt + out_cnt > peak_fill)
            peak_fill = in_cnt + out_cnt;
        return r;
    endfunction

    // Values lean on the extremes and on a small range so ties and
    // max changes happen often; the rest are full 32-bit random.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return EMPTY_SENTINEL;
            3, 4:    return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic opcode_t pick_opcode(burst_kind_t kind);
        int r;
        r = $urandom_range(99);
        case (kind)
            BURST_FILL:  return (r < 80) ? OP_ENQUEUE : opcode_t'($urandom_range(3));
            BURST_DRAIN: return (r < 70) ? OP_DEQUEUE : opcode_t'($urandom_range(3));
            default:     return opcode_t'($urandom_range(3));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, and the hard stop in case the core hangs.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("max_tracking_fifo_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink: random back-pressure, plus a long hold-off whenever the
    // sequence bumps hold_trigger. The hold is counted here, so the
    // source keeps offering requests the whole time.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Scoreboard: each response against the oldest expectation.
    // Outputs are sampled at the edge, before any update lands.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        response_t exp_resp;
        if (rst_n && m_tvalid && m_tready)
        begin
            responses_seen++;
            if (expected_responses.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: response with none pending: value %0d, flags %b",
                             $time, $signed(m_tdata), m_tuser);
                mismatches++;
            end
            else
            begin
                exp_resp = expected_responses.pop_front();
                if (m_tdata !== exp_resp.value || m_tuser[0] !== exp_resp.is_empty ||
                    m_tuser[2:1] !== exp_resp.status)
                begin
                    if (mismatches < 10)
                        $display("%0t: response %0d: value %0d/%0d empty %b/%b status %0d/%0d %s",
                                 $time, responses_seen, $signed(m_tdata), exp_resp.value,
                                 m_tuser[0], exp_resp.is_empty, m_tuser[2:1],
                                 exp_resp.status, "(got/expected)");
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Source: optional idle gap, then hold the request until taken.
    // The model is stepped at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_request(input opcode_t op, input logic [31:0] val,
                                input bit typed, input response_t typed_resp);
        response_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_response(op, val);
        expected_responses.push_back(typed ? typed_resp : predicted);
        requests_sent++;
    endtask

    // Source goes quiet until every owed response is back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          phase_idle  [NUM_PHASES];
        int          phase_stall [NUM_PHASES];
        int          phase_count;
        int          burst_len;
        burst_kind_t kind;
        response_t   typed_resp;
        response_t   unused_resp;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_EMPTY;
        m_tready = 1'b0;

        send_idle_pct = 0;
        stall_pct     = 0;
        hold_trigger  = 0;
        hold_seen     = 0;
        hold_left     = 0;
        in_cnt        = 0;
        out_cnt       = 0;
        requests_sent = 0;
        responses_seen = 0;
        mismatches    = 0;
        full_drops    = 0;
        empty_hits    = 0;
        stack_moves   = 0;
        peak_fill     = 0;
        unused_resp   = '0;

        // Idling plan per phase: none, source gaps, sink stalls, both.
        phase_idle  = '{0, 54, 0, 37};
        phase_stall = '{0, 0, 54, 37};

        directed_rows = '{
            // empty queue straight out of reset
            '{OP_EMPTY,   32'h0000_0000, 1'b1, 32'sd0,         1'b1, ST_OK},
            '{OP_DEQUEUE, 32'hffff_ffff, 1'b1, EMPTY_SENTINEL, 1'b1, ST_EMPTY},
            '{OP_MAXIMUM, 32'h0000_0000, 1'b1, EMPTY_SENTINEL, 1'b1, ST_EMPTY},
            // most negative value is a real value, not the sentinel
            '{OP_ENQUEUE, 32'h8000_0000, 1'b1, 32'sd0,         1'b0, ST_OK},
            '{OP_MAXIMUM, 32'hffff_ffff, 1'b1, 32'sh8000_0000, 1'b0, ST_OK},
            '{OP_EMPTY,   32'hffff_ffff, 1'b1, 32'sd0,         1'b0, ST_OK},
            '{OP_ENQUEUE, 32'h7fff_ffff, 1'b1, 32'sd0,         1'b0, ST_OK},
            '{OP_MAXIMUM, 32'h0000_0000, 1'b1, 32'sh7fff_ffff, 1'b0, ST_OK},
            // first dequeue moves the input stack over
            '{OP_DEQUEUE, 32'h0000_0000, 1'b1, 32'sh8000_0000, 1'b0, ST_OK},
            '{OP_MAXIMUM, 32'hffff_ffff, 1'b1, 32'sh7fff_ffff, 1'b0, ST_OK},
            '{OP_ENQUEUE, 32'h0000_0005, 1'b1, 32'sd0,         1'b0, ST_OK},
            // both stacks populated
            '{OP_MAXIMUM, 32'h0000_0000, 1'b1, 32'sh7fff_ffff, 1'b0, ST_OK},
            '{OP_DEQUEUE, 32'hffff_ffff, 1'b1, 32'sh7fff_ffff, 1'b0, ST_OK},
            '{OP_MAXIMUM, 32'h0000_0000, 1'b1, 32'sd5,         1'b0, ST_OK},
            '{OP_DEQUEUE, 32'h0000_0000, 1'b1, 32'sd5,         1'b1, ST_OK},
            '{OP_DEQUEUE, 32'hffff_ffff, 1'b1, EMPTY_SENTINEL, 1'b1, ST_EMPTY},
            // a stored value equal to the sentinel still reports ok
            '{OP_ENQUEUE, EMPTY_SENTINEL, 1'b1, 32'sd0,        1'b0, ST_OK},
            '{OP_MAXIMUM, 32'h0000_0000, 1'b1, EMPTY_SENTINEL, 1'b0, ST_OK},
            // mixed traffic, scored by the model
            '{OP_ENQUEUE, 32'h0000_0003, 1'b0, 32'sd0,         1'b0, ST_OK},
            '{OP_ENQUEUE, 32'hffff_fff9, 1'b0, 32'sd0,         1'b0, ST_OK},
            '{OP_DEQUEUE, 32'h0000_0000, 1'b0, 32'sd0,         1'b0, ST_OK},
            '{OP_ENQUEUE, 32'h0000_0009, 1'b0, 32'sd0,         1'b0, ST_OK},
            '{OP_MAXIMUM, 32'h0000_0000, 1'b0, 32'sd0,         1'b0, ST_OK},
            '{OP_DEQUEUE, 32'hffff_ffff, 1'b0, 32'sd0,         1'b0, ST_OK},
            '{OP_EMPTY,   32'h0000_0000, 1'b0, 32'sd0,         1'b0, ST_OK}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            typed_resp.value    = directed_rows[i].exp_value;
            typed_resp.is_empty = directed_rows[i].exp_empty;
            typed_resp.status   = directed_rows[i].exp_status;
            send_request(directed_rows[i].op, directed_rows[i].value,
                         directed_rows[i].typed, typed_resp);
        end
        wait_drained();

        // Random phases, each a run of bursts biased to fill, drain or mix.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = phase_idle[p];
            stall_pct     = phase_stall[p];
            phase_count   = 0;

            // Overrun the capacity once so dropped enqueues show up early.
            if (p == 0)
            begin
                for (int i = 0; i < DEPTH + 6; i++)
                    send_request(OP_ENQUEUE, pick_value(), 1'b0, unused_resp);
                phase_count = DEPTH + 6;
            end

            // Sink holds off for a long stretch; source keeps offering.
            if (p == 2)
                hold_trigger++;

            while (phase_count < PHASE_REQUESTS)
            begin
                kind      = burst_kind_t'($urandom_range(2));
                burst_len = $urandom_range(10, 40);
                for (int i = 0; i < burst_len && phase_count < PHASE_REQUESTS; i++)
                begin
                    send_request(pick_opcode(kind), pick_value(), 1'b0, unused_resp);
                    phase_count++;
                end
            end

            // Source pauses until everything owed has come back.
            wait_drained();
        end

        s_tvalid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        // Room for a stray late response after a full-depth stack move.
        repeat (DEPTH + 8) @(posedge clk);

        $display("Ran %0d requests, %0d responses; %0d full drops, %0d empty hits",
                 requests_sent, responses_seen, full_drops, empty_hits);
        $display("%0d stack moves, peak occupancy %0d of %0d; %0d mismatches",
                 stack_moves, peak_fill, DEPTH, mismatches);
        if (mismatches == 0)
            $display("max_tracking_fifo_core: match");
        else
            $display("max_tracking_fifo_core: mismatch");
        $finish;
    end

endmodule

FILE: max_tracking_fifo_core.f
+incdir+rtl/core
rtl/core/mtf_pkg.sv
rtl/core/mtf_stack.sv
rtl/core/max_tracking_fifo_core.sv
rtl/core/mtf_checker.sv
tb/max_tracking_fifo_core_tb.sv
